// ===== sv/ssg_pkg.sv =====
// Shared types and constants for the scheduled spike generator.
// No dependencies.
`timescale 1ns / 1ps
package ssg_pkg;
    localparam int NEURONS   = 64;
    localparam int SLOTS     = 8;
    localparam int STEP_BITS = 32;
    localparam int N_BITS    = 6;
    localparam int S_BITS    = 3;
    localparam int A_BITS    = N_BITS + S_BITS;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [5:0]  neuron;
        logic [2:0]  slot;
        logic [31:0] start_step;
        logic [31:0] end_step;
        logic [31:0] period;
        logic        is_last;
        logic [31:0] tick_step;
    } in_item_t;

    typedef struct packed {
        logic [5:0] neuron_out;
        logic       spike;
        logic       last_of_tick;
    } out_item_t;

    // one stored instruction; done is the completed flag
    typedef struct packed {
        logic [STEP_BITS-1:0] start_step;
        logic [STEP_BITS-1:0] end_step;
        logic [STEP_BITS-1:0] period;
        logic                 is_last;
        logic                 done;
    } instr_t;
endpackage

// ===== sv/scheduled_spike_generator.sv =====
// Top level of the scheduled spike generator: instruction memory, slot
// memory, tick sequencer. Depends on ssg_pkg and ssg_divmod.
`timescale 1ns / 1ps
// Usage
//  s_ channel takes requests: a load writes one instruction of one neuron
//  into the instruction memory (64 x 8 entries); a tick walks neurons 0..63
//  and emits one m_ request per neuron, last_of_tick on neuron 63.
//  Load: written to memory in the cycle after it is accepted; no result.
//  Tick: per neuron, a slot memory read (ST_SLOT), an instruction read
//  (ST_READ), a compare and write-back (ST_EVAL), then when the neuron may
//  fire a 32-step remainder unit (one quotient bit per cycle, in ST_DIV),
//  then posting of the result (ST_POST). Output stalls lengthen a tick;
//  the serial remainder sets the rate.
//  One request is handled at a time; s_ready is low during a tick, so no
//  two accesses to one memory entry ever overlap.
//  Result sits in a single output register; when the receiver stalls the
//  sequencer waits in its post state until the register empties.
//  Reset (aresetn, synchronous) empties the output register and starts a
//  pass that clears the active slot of every neuron; s_ready stays low
//  until it ends. The instruction memory holds rubbish until loaded;
//  every neuron needs its first slot loaded before the first tick.
module scheduled_spike_generator
    import ssg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_CLEAR = 8'b00000010,
        ST_SLOT  = 8'b00000100,
        ST_READ  = 8'b00001000,
        ST_EVAL  = 8'b00010000,
        ST_DIV   = 8'b00100000,
        ST_POST  = 8'b01000000,
        ST_LOAD  = 8'b10000000
    } state_t;

    state_t               state_reg, state_next;
    in_item_t             req_reg;
    logic [N_BITS-1:0]    nrn_reg;

    // active slot memory: one write port, one registered read port
    logic [S_BITS-1:0]    slot_mem [NEURONS];
    logic [S_BITS-1:0]    slot_rd_reg;
    logic                 slot_we;
    logic [S_BITS-1:0]    slot_wdata;

    // instruction memory: one write port, one registered read port
    instr_t               mem [NEURONS*SLOTS];
    instr_t               rd_reg;
    logic                 mem_we;
    logic [A_BITS-1:0]    mem_waddr;
    instr_t               mem_wdata;
    logic [A_BITS-1:0]    mem_raddr;

    logic                 ended;
    logic                 cand_reg;
    logic                 fire_reg;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_zero;
    logic                 post_go;
    logic                 mv_reg;
    out_item_t            md_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;
    assign m_data   = md_reg;
    assign mem_raddr = {nrn_reg, slot_rd_reg};
    assign ended    = (rd_reg.end_step <= req_reg.tick_step);
    assign post_go  = (state_reg == ST_POST) && (!mv_reg || m_ready);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {nrn_reg, slot_rd_reg};
        mem_wdata = rd_reg;
        if (state_reg == ST_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = {req_reg.neuron, req_reg.slot};
            mem_wdata = '{start_step: req_reg.start_step, end_step: req_reg.end_step,
                          period: req_reg.period, is_last: req_reg.is_last,
                          done: 1'b0};
        end else if (state_reg == ST_EVAL && ended) begin
            mem_we         = 1'b1;
            mem_wdata.done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[mem_raddr];
    end

    // clearing pass after reset; slot advance on completion of a non-last
    // instruction, wrapping past the final slot
    always_comb begin
        slot_we    = 1'b0;
        slot_wdata = slot_rd_reg + 1'b1;
        if (state_reg == ST_CLEAR) begin
            slot_we    = 1'b1;
            slot_wdata = '0;
        end else if (state_reg == ST_EVAL && ended && !rd_reg.is_last) begin
            slot_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[nrn_reg] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[nrn_reg];
    end

    assign div_start = (state_reg == ST_EVAL) && !ended && (rd_reg.period != '0)
                       && !rd_reg.done && (rd_reg.start_step < req_reg.tick_step);

    ssg_divmod u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (req_reg.tick_step - rd_reg.start_step),
        .divisor  (rd_reg.period),
        .busy     (div_busy),
        .zero_rem (div_zero)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.operation == OP_TICK) ? ST_SLOT : ST_LOAD;
                end
            end
            ST_CLEAR: begin
                if (nrn_reg == N_BITS'(NEURONS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_SLOT: state_next = ST_READ;
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: state_next = div_start ? ST_DIV : ST_POST;
            ST_DIV:  state_next = (!div_busy && !cand_reg) ? ST_POST : ST_DIV;
            ST_POST: begin
                if (post_go) begin
                    state_next = (nrn_reg == N_BITS'(NEURONS - 1)) ? ST_IDLE : ST_SLOT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mv_reg    <= 1'b0;
            nrn_reg   <= '0;
            cand_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cand_reg  <= div_start;
            if (post_go) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (post_go || state_reg == ST_CLEAR) begin
                nrn_reg <= nrn_reg + 1'b1;
            end else if (state_reg == ST_IDLE && s_valid) begin
                nrn_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_EVAL) begin
            fire_reg <= 1'b0;
        end else if (state_reg == ST_DIV && !div_busy && !cand_reg) begin
            fire_reg <= div_zero;
        end
        if (post_go) begin
            md_reg.neuron_out   <= nrn_reg;
            md_reg.spike        <= fire_reg;
            md_reg.last_of_tick <= (nrn_reg == N_BITS'(NEURONS - 1));
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE)) else $error("ready outside idle");
    a_no_spike_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && rd_reg.done) |=> !fire_reg)
        else $error("spike on completed instruction");
    a_div_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_DIV)) else $error("divider busy out of place");
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_of_tick) |-> (m_data.neuron_out == N_BITS'(NEURONS - 1)))
        else $error("last flag on wrong neuron");
`endif
endmodule

// ===== sv/ssg_divmod.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on ssg_pkg.
`timescale 1ns / 1ps
module ssg_divmod
    import ssg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [STEP_BITS-1:0] dividend,
    input  logic [STEP_BITS-1:0] divisor,
    output logic                 busy,
    output logic                 zero_rem
);
    localparam int CNT_BITS = $clog2(STEP_BITS + 1);

    logic [STEP_BITS-1:0] quo_reg;
    logic [STEP_BITS:0]   rem_reg;
    logic [STEP_BITS-1:0] div_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic [STEP_BITS:0]   shifted;
    logic [STEP_BITS:0]   diff;

    assign shifted  = {rem_reg[STEP_BITS-1:0], quo_reg[STEP_BITS-1]};
    assign diff     = shifted - {1'b0, div_reg};
    assign busy     = busy_reg;
    assign zero_rem = (rem_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(STEP_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[STEP_BITS-2:0], 1'b0};
            rem_reg <= diff[STEP_BITS] ? shifted : diff;
        end
    end
endmodule

// ===== bench/scheduled_spike_generator_tb.sv =====
// Self-checking bench for scheduled_spike_generator: random load and tick
// requests against an in-bench schedule predictor. Depends on ssg_pkg and scheduled_spike_generator.
`timescale 1ns / 1ps

// Tracks the per-neuron instruction table and queues predicted results.
class spike_scoreboard;
    ssg_pkg::instr_t   table_mem [ssg_pkg::NEURONS*ssg_pkg::SLOTS];
    bit                written   [ssg_pkg::NEURONS*ssg_pkg::SLOTS];
    logic [2:0]        cur_slot  [ssg_pkg::NEURONS];
    ssg_pkg::out_item_t pending_spikes[$];
    int                errors;

    function new();
        errors = 0;
        foreach (cur_slot[i]) cur_slot[i] = '0;
        foreach (table_mem[i]) table_mem[i] = '0;
        foreach (written[i]) written[i] = 1'b0;
    endfunction

    // note an accepted request; ticks queue one prediction per neuron
    function void note_request(ssg_pkg::in_item_t r);
        int idx;
        logic [31:0] t;
        logic [31:0] diff;
        ssg_pkg::out_item_t o;
        if (r.operation == ssg_pkg::OP_LOAD) begin
            idx = r.neuron * ssg_pkg::SLOTS + r.slot;
            table_mem[idx].start_step = r.start_step;
            table_mem[idx].end_step   = r.end_step;
            table_mem[idx].period     = r.period;
            table_mem[idx].is_last    = r.is_last;
            table_mem[idx].done       = 1'b0;
            written[idx]              = 1'b1;
        end else begin
            t = r.tick_step;
            for (int n = 0; n < ssg_pkg::NEURONS; n++) begin
                idx = n * ssg_pkg::SLOTS + cur_slot[n];
                if (table_mem[idx].end_step <= t) begin
                    if (!table_mem[idx].is_last) cur_slot[n] = cur_slot[n] + 1'b1;
                    table_mem[idx].done = 1'b1;
                end
                o.neuron_out   = n[5:0];
                o.spike        = 1'b0;
                o.last_of_tick = (n == ssg_pkg::NEURONS - 1);
                if (table_mem[idx].period != 0 && !table_mem[idx].done
                    && table_mem[idx].start_step < t) begin
                    diff = t - table_mem[idx].start_step;
                    o.spike = (diff % table_mem[idx].period) == 0;
                end
                pending_spikes = {pending_spikes, o};
            end
        end
    endfunction

    function void check_result(ssg_pkg::out_item_t got);
        ssg_pkg::out_item_t exp_r;
        if (pending_spikes.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = pending_spikes.pop_front();
        if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected n=%0d s=%0b l=%0b, got n=%0d s=%0b l=%0b",
                         exp_r.neuron_out, exp_r.spike, exp_r.last_of_tick,
                         got.neuron_out, got.spike, got.last_of_tick);
        end
    endfunction
endclass

module scheduled_spike_generator_tb;
    import ssg_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    spike_scoreboard sb;
    bit  quiet_phase;     // no idling on either side at the end
    bit  hold_receiver;   // long receiver hold-off requested
    int  hold_cycles;
    logic [31:0] now_step; // running time base for ticks

    scheduled_spike_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous cap on the run time, receiver stalls included.
    initial begin
        #400ms;
        $display("scheduled_spike_generator test failed");
        $finish;
    end

    // Receiver: random ready bursts, plus an optional long hold-off.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_receiver) begin
                m_ready = 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_receiver = 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 8);
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Check each accepted result at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Offer one request; valid stays up until the handshake.
    task automatic send_request(in_item_t r);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_load(int n, int sl, logic [31:0] st, logic [31:0] en,
                             logic [31:0] pd, logic last);
        in_item_t r;
        r = '0;
        r.operation  = OP_LOAD;
        r.neuron     = n[5:0];
        r.slot       = sl[2:0];
        r.start_step = st;
        r.end_step   = en;
        r.period     = pd;
        r.is_last    = last;
        r.tick_step  = $urandom;
        send_request(r);
    endtask

    // A tick first makes sure every neuron's active entry has been loaded.
    task automatic send_tick(logic [31:0] t);
        in_item_t r;
        fill_active();
        r = '0;
        {r.neuron, r.slot} = A_BITS'($urandom);
        r.start_step = $urandom;
        r.end_step   = $urandom;
        r.period     = $urandom;
        r.is_last    = 1'($urandom);
        r.operation  = OP_TICK;
        r.tick_step  = t;
        send_request(r);
    endtask

    // Random period, mostly short so modulo hits happen; also zero and large values.
    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 7);
        endcase
    endfunction

    // Load a final instruction into any active slot never written so far.
    task automatic fill_active();
        int idx;
        for (int n = 0; n < NEURONS; n++) begin
            idx = n * SLOTS + sb.cur_slot[n];
            if (!sb.written[idx])
                send_load(n, int'(sb.cur_slot[n]), now_step,
                          now_step + $urandom_range(1, 20), rand_period(), 1'b1);
        end
    endtask

    // Write a whole random schedule for one neuron, slots 0..len-1.
    task automatic load_schedule(int n);
        int len;
        logic [31:0] st;
        len = $urandom_range(1, SLOTS);
        st  = now_step;
        for (int s = 0; s < len; s++) begin
            send_load(n, s, st, st + $urandom_range(1, 20), rand_period(),
                      (s == len - 1) ? ($urandom_range(0, 3) != 0) : 1'b0);
            st = st + $urandom_range(0, 20);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending_spikes.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int sent;
        sb = new();
        quiet_phase   = 1'b0;
        hold_receiver = 1'b0;
        hold_cycles   = 0;
        now_step      = 32'd0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: slot 0 of every neuron, extremes spread over neurons.
        // Only neurons 1 to 3 go on past slot 0.
        for (int n = 0; n < NEURONS; n++)
            send_load(n, 0, 32'd0, 32'd10, (n % 4 == 0) ? 32'd0 : n % 5 + 1,
                      (n == 0 || n > 3));
        send_load(1, 1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_load(2, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
        send_load(63, 7, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
        for (int s = 1; s < SLOTS; s++)
            send_load(3, s, s, s + 2, 32'd1, 1'b0);   // runs past slot 7, wraps
        send_tick(32'd0);             // start not below time: no spikes
        send_tick(32'd6);             // modulo hits
        send_tick(32'd10);            // end reached: complete on this tick
        send_tick(32'hFFFF_FFFF);     // far end; last instruction completes
        send_tick(32'hFFFF_FFFF);     // completed last stays silent
        wait_drained();
        now_step = 32'h7FFF_FFF0;

        // Fresh schedules, then the receiver holds off while ticks pile up.
        sent = 0;
        for (int k = 0; k < 8; k++) begin
            load_schedule($urandom_range(0, NEURONS - 1));
        end
        hold_cycles   = 400;
        hold_receiver = 1'b1;
        send_tick(now_step);
        send_tick(now_step + 1);
        wait_drained();

        // Random part: mostly well-formed reloads and advancing ticks.
        while (sent < 150) begin
            if ($urandom_range(0, 3) == 0) begin
                send_tick(now_step);
                now_step = now_step + $urandom_range(0, 6);
            end else if ($urandom_range(0, 9) == 0) begin
                send_load($urandom_range(0, NEURONS - 1), $urandom_range(0, SLOTS - 1),
                          $urandom, $urandom, $urandom, 1'($urandom));
            end else begin
                send_load($urandom_range(0, NEURONS - 1), $urandom_range(0, SLOTS - 1),
                          now_step, now_step + $urandom_range(0, 30), rand_period(),
                          1'($urandom_range(0, 1)));
            end
            sent++;
            if (sent == 110) quiet_phase = 1'b1;
        end
        send_tick(now_step);

        wait_drained();
        repeat (50) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_spikes.size() == 0)
            $display("scheduled_spike_generator test passed");
        else
            $display("scheduled_spike_generator test failed");
        $finish;
    end
endmodule
